[src/i64div_pkg.sv]
// package for the 64-bit divider: widths and stage count
package i64div_pkg;
	localparam int unsigned DATA_W = 64;
	localparam int unsigned BITS_PER_STAGE = 4;
	localparam int unsigned DIV_STAGES = DATA_W / BITS_PER_STAGE;
	localparam logic [DATA_W-1:0] SIGN_MASK = {1'b1, {(DATA_W-1){1'b0}}};
endpackage

[src/int64_divider.sv]
// 64-bit signed/unsigned pipelined restoring divider, top level
// An item is taken whenever start is high and busy is low; busy is never raised, so one item
// can enter every cycle. Each result appears on done for one cycle, after the item has passed
// the first register, which takes magnitudes, sixteen stages that each retire four quotient
// bits, and the output register, which fixes signs. The receiver cannot stall.
module int64_divider #(
	parameter int unsigned STAGES = i64div_pkg::DIV_STAGES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [i64div_pkg::DATA_W-1:0] dividend,
	input  logic [i64div_pkg::DATA_W-1:0] divisor,
	output logic                          done,
	output logic [i64div_pkg::DATA_W-1:0] quotient,
	output logic [i64div_pkg::DATA_W-1:0] remainder,
	output logic                          divide_by_zero
);
	import i64div_pkg::*;

	localparam int unsigned BPS = DATA_W / STAGES;

	typedef struct packed {
		logic              zero;
		logic              neg_q;
		logic              neg_r;
		logic [DATA_W-1:0] orig;
	} ctl_t;

	logic              v_s1;
	ctl_t              c_s1;
	logic [DATA_W-1:0] n_s1, d_s1;

	logic              v_p [STAGES+1];
	ctl_t              c_p [STAGES+1];
	logic [DATA_W-1:0] n_p [STAGES+1];
	logic [DATA_W-1:0] d_p [STAGES+1];
	logic [DATA_W-1:0] q_p [STAGES+1];
	logic [DATA_W-1:0] r_p [STAGES+1];

	logic a_neg, b_neg;

	assign busy  = 1'b0;
	assign a_neg = kind & dividend[DATA_W-1];
	assign b_neg = kind & divisor[DATA_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_s1       <= a_neg ? (~dividend + 1'b1) : dividend;
			d_s1       <= b_neg ? (~divisor + 1'b1) : divisor;
			c_s1.zero  <= (divisor == '0);
			c_s1.neg_q <= a_neg ^ b_neg;
			c_s1.neg_r <= a_neg;
			c_s1.orig  <= dividend;
		end
	end

	assign v_p[0] = v_s1;
	assign c_p[0] = c_s1;
	assign n_p[0] = n_s1;
	assign d_p[0] = d_s1;
	assign q_p[0] = '0;
	assign r_p[0] = '0;

	for (genvar s = 0; s < STAGES; s++) begin : g_stage
		logic [DATA_W-1:0] r_c [BPS+1];
		logic [DATA_W-1:0] q_c [BPS+1];
		assign r_c[0] = r_p[s];
		assign q_c[0] = q_p[s];
		for (genvar k = 0; k < BPS; k++) begin : g_bit
			logic              cy;
			logic [DATA_W-1:0] sh;
			logic              take;
			assign cy   = r_c[k][DATA_W-1];
			assign sh   = {r_c[k][DATA_W-2:0], n_p[s][DATA_W-1-(s*BPS+k)]};
			assign take = cy | (sh >= d_p[s]);
			assign r_c[k+1] = take ? (sh - d_p[s]) : sh;
			assign q_c[k+1] = {q_c[k][DATA_W-2:0], take};
		end
		logic              v_q;
		ctl_t              c_q;
		logic [DATA_W-1:0] n_q, d_q, q_q, r_q;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q <= 1'b0;
			end else begin
				v_q <= v_p[s];
			end
		end
		always_ff @(posedge clk) begin
			if (v_p[s]) begin
				c_q <= c_p[s];
				n_q <= n_p[s];
				d_q <= d_p[s];
				q_q <= q_c[BPS];
				r_q <= r_c[BPS];
			end
		end
		assign v_p[s+1] = v_q;
		assign c_p[s+1] = c_q;
		assign n_p[s+1] = n_q;
		assign d_p[s+1] = d_q;
		assign q_p[s+1] = q_q;
		assign r_p[s+1] = r_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_p[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (v_p[STAGES]) begin
			if (c_p[STAGES].zero) begin
				quotient  <= '1;
				remainder <= c_p[STAGES].orig;
			end else begin
				quotient  <= c_p[STAGES].neg_q ? (~q_p[STAGES] + 1'b1) : q_p[STAGES];
				remainder <= c_p[STAGES].neg_r ? (~r_p[STAGES] + 1'b1) : r_p[STAGES];
			end
			divide_by_zero <= c_p[STAGES].zero;
		end
	end

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		v_p[STAGES] |=> done)
		else $error("result lost at output");
	a_zero_q: assert property (@(posedge clk) disable iff (!arst_n)
		done && divide_by_zero |-> quotient == '1)
		else $error("zero divisor quotient wrong");
	a_rem_small: assert property (@(posedge clk) disable iff (!arst_n)
		v_p[STAGES] && !c_p[STAGES].zero |-> r_p[STAGES] < d_p[STAGES])
		else $error("remainder not below divisor");
	a_min: assert property (@(posedge clk) disable iff (!arst_n)
		v_p[STAGES] && !c_p[STAGES].zero && n_p[STAGES] == SIGN_MASK
		&& d_p[STAGES] == 64'd1 |-> q_p[STAGES] == SIGN_MASK)
		else $error("minimum magnitude divide wrong");
endmodule
